// ----- design/tphi_pkg.sv -----
package tphi_pkg;

  localparam int DEF_HISTORY_DEPTH = 64;

  localparam int TIME_W = 48;
  localparam int POS_W  = 19;
  localparam int ANG_W  = 18;

  // angle constants, 1/128 degree
  localparam int HALF_TURN = 23040;
  localparam int FULL_TURN = 46080;

  localparam int POS_MIN = -262144;
  localparam int POS_MAX = 262143;
  localparam int ANG_MIN = -115200;
  localparam int ANG_MAX = 115199;

  // input action codes
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // read address select
  localparam logic [1:0] RD_OLDEST = 2'd0;
  localparam logic [1:0] RD_NEWEST = 2'd1;
  localparam logic [1:0] RD_NEXT1  = 2'd2;
  localparam logic [1:0] RD_NEXT2  = 2'd3;

  // interpolation lanes
  localparam logic [1:0] LANE_X   = 2'd0;
  localparam logic [1:0] LANE_Y   = 2'd1;
  localparam logic [1:0] LANE_HDG = 2'd2;
  localparam logic [1:0] LANE_TUR = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [ANG_W-1:0]  hdg;
    logic [ANG_W-1:0]  tur;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic       wr;
    logic       latch_t;
    logic       k_clr;
    logic       k_inc;
    logic       rd;
    logic [1:0] rd_sel;
    logic       ld_zero;
    logic       ld_a_rd;
    logic       ld_b_rd;
    logic       ld_ab_last;
    logic       ld_last;
    logic       f_clr;
    logic       f_one;
    logic       div_init;
    logic       div_step;
    logic       ld_diff;
    logic       ld_prod;
    logic       ld_res;
    logic [1:0] lane;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic t_le_rd;
    logic t_ge_rd;
    logic bracket;
    logic scan_end;
    logic den_zero;
    logic num_ge;
  } status_t;

endpackage

// ----- design/timestamped_pose_history_interp_top.sv -----
// Add: accepted back to back; busy stays low.
// Query: done_o rises after the oldest and newest reads, a bracket scan set by the
//   one-entry-per-cycle walk of the single RAM read port, the 16-step serial divider
//   with its DIV_INIT and DIV_CHK set-up states, and the shared multiplier over four
//   lanes; busy drops the cycle after.
// Results show for one cycle on done_o; the receiver cannot stall. Reset (async,
//   rst_ni low) empties the history; the RAM needs no clearing.
module timestamped_pose_history_interp_top
  import tphi_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    action_i,
  input  logic [TIME_W-1:0]       sample_time_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [ANG_W-1:0] heading_i,
  input  logic signed [ANG_W-1:0] turret_i,
  output logic                    done_o,
  output logic signed [POS_W-1:0] out_x_o,
  output logic signed [POS_W-1:0] out_y_o,
  output logic signed [ANG_W-1:0] out_heading_o,
  output logic signed [ANG_W-1:0] out_turret_o
);

  // Controller sequences the query: oldest, newest, bracket walk,
  // fraction divide, then per-lane diff / multiply / add-saturate.
  cmd_t    cmd;
  status_t status;

  tphi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .action_i(action_i),
    .status_i(status),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Datapath holds the ring RAM, pointers, divider and lerp lanes.
  tphi_dp #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_time_i(sample_time_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .heading_i    (heading_i),
    .turret_i     (turret_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_heading_o(out_heading_o),
    .out_turret_o (out_turret_o)
  );

`ifndef SYNTH
  // a result transfer only happens mid-query
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done_o outside a query");

  // strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done_o held");

  // an add yields no result
  a_add_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == ACT_ADD)) |=> !busy && !done_o)
    else $error("add caused activity");

  // a query always occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (action_i == ACT_QUERY)) |=> busy && !done_o)
    else $error("query not taken");
`endif

endmodule

// ----- design/tphi_ram.sv -----
module tphi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tphi_ctrl.sv -----
module tphi_ctrl
  import tphi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    action_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD_FIRST = 4'd1;
  localparam logic [3:0] S_RD_LAST  = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_DIV_INIT = 4'd4;
  localparam logic [3:0] S_DIV_CHK  = 4'd5;
  localparam logic [3:0] S_DIV_STEP = 4'd6;
  localparam logic [3:0] S_L_DIFF   = 4'd7;
  localparam logic [3:0] S_L_MUL    = 4'd8;
  localparam logic [3:0] S_L_ADD    = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.lane = cnt_q[1:0];
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (action_i == ACT_ADD) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.latch_t = 1'b1;
            cmd_o.k_clr   = 1'b1;
            cnt_d         = '0;
            if (status_i.cnt_zero) begin
              cmd_o.ld_zero = 1'b1;
              cmd_o.f_clr   = 1'b1;
              state_d       = S_L_DIFF;
            end else begin
              cmd_o.rd     = 1'b1;
              cmd_o.rd_sel = RD_OLDEST;
              state_d      = S_RD_FIRST;
            end
          end
        end
      end
      S_RD_FIRST: begin
        cmd_o.ld_a_rd = 1'b1;
        cmd_o.ld_b_rd = 1'b1;
        cmd_o.f_clr   = 1'b1;
        if (status_i.cnt_one || status_i.t_le_rd) begin
          state_d = S_L_DIFF;
        end else begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = RD_NEWEST;
          state_d      = S_RD_LAST;
        end
      end
      S_RD_LAST: begin
        cmd_o.ld_last = 1'b1;
        if (status_i.t_ge_rd) begin
          cmd_o.ld_a_rd = 1'b1;
          cmd_o.ld_b_rd = 1'b1;
          state_d       = S_L_DIFF;
        end else begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = RD_NEXT1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status_i.bracket) begin
          cmd_o.ld_b_rd = 1'b1;
          state_d       = S_DIV_INIT;
        end else if (status_i.scan_end) begin
          cmd_o.ld_ab_last = 1'b1;
          cmd_o.f_clr      = 1'b1;
          state_d          = S_L_DIFF;
        end else begin
          cmd_o.ld_a_rd = 1'b1;
          cmd_o.k_inc   = 1'b1;
          cmd_o.rd      = 1'b1;
          cmd_o.rd_sel  = RD_NEXT2;
        end
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV_CHK;
      end
      S_DIV_CHK: begin
        cnt_d = '0;
        if (status_i.den_zero) begin
          cmd_o.f_clr = 1'b1;
          state_d     = S_L_DIFF;
        end else if (status_i.num_ge) begin
          cmd_o.f_one = 1'b1;
          state_d     = S_L_DIFF;
        end else begin
          state_d = S_DIV_STEP;
        end
      end
      S_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = S_L_DIFF;
        end
      end
      S_L_DIFF: begin
        cmd_o.ld_diff = 1'b1;
        state_d       = S_L_MUL;
      end
      S_L_MUL: begin
        cmd_o.ld_prod = 1'b1;
        state_d       = S_L_ADD;
      end
      S_L_ADD: begin
        cmd_o.ld_res = 1'b1;
        cnt_d        = cnt_q + 4'd1;
        if (cnt_q[1:0] == LANE_TUR) begin
          state_d = S_DONE;
        end else begin
          state_d = S_L_DIFF;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ----- design/tphi_dp.sv -----
module tphi_dp
  import tphi_pkg::*;
#(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [TIME_W-1:0]       sample_time_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [ANG_W-1:0] heading_i,
  input  logic signed [ANG_W-1:0] turret_i,
  output logic signed [POS_W-1:0] out_x_o,
  output logic signed [POS_W-1:0] out_y_o,
  output logic signed [ANG_W-1:0] out_heading_o,
  output logic signed [ANG_W-1:0] out_turret_o
);

  localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int DW = POS_W + 2;   // lane difference
  localparam int PW = DW + 18;     // product
  localparam int SW = DW + 3;      // sum before saturation
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

  localparam logic signed [SW-1:0] POS_LO = SW'(POS_MIN);
  localparam logic signed [SW-1:0] POS_HI = SW'(POS_MAX);
  localparam logic signed [SW-1:0] ANG_LO = SW'(ANG_MIN);
  localparam logic signed [SW-1:0] ANG_HI = SW'(ANG_MAX);
  localparam logic signed [DW-1:0] HALF_C = DW'(HALF_TURN);
  localparam logic signed [DW-1:0] FULL_C = DW'(FULL_TURN);

  // ring pointers
  logic [IW-1:0] oldest_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] k_q;

  entry_t            a_q, b_q, last_q, rd_entry, wr_entry;
  logic [TIME_W-1:0] t_q;
  logic [16:0]       f_q;
  logic [TIME_W-1:0] rem_q, den_q;
  logic signed [DW-1:0] diff_q;
  logic signed [PW-1:0] prod_q;
  logic signed [POS_W-1:0] out_x_q, out_y_q;
  logic signed [ANG_W-1:0] out_hdg_q, out_tur_q;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                         input logic [CW-1:0] idx);
    logic [CW:0] s;
    s = {1'b0, idx} + (CW+1)'(base);
    if (s >= (CW+1)'(HISTORY_DEPTH)) begin
      s = s - (CW+1)'(HISTORY_DEPTH);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] lane_val(input entry_t e,
                                                     input logic [1:0] ln);
    logic signed [DW-1:0] v;
    case (ln)
      LANE_X:   v = DW'(signed'(e.x));
      LANE_Y:   v = DW'(signed'(e.y));
      LANE_HDG: v = DW'(signed'(e.hdg));
      LANE_TUR: v = DW'(signed'(e.tur));
      default:  v = '0;
    endcase
    return v;
  endfunction

  // write path
  logic          full;
  logic [IW-1:0] waddr;
  assign full  = (count_q == DEPTH_C);
  assign waddr = full ? oldest_q : slot(oldest_q, count_q);
  assign wr_entry = '{ts: sample_time_i, x: pos_x_i, y: pos_y_i,
                      hdg: heading_i, tur: turret_i};

  // read address
  logic [IW-1:0] raddr;
  always_comb begin
    case (cmd_i.rd_sel)
      RD_OLDEST: raddr = oldest_q;
      RD_NEWEST: raddr = slot(oldest_q, count_q - CW'(1));
      RD_NEXT1:  raddr = slot(oldest_q, k_q + CW'(1));
      RD_NEXT2:  raddr = slot(oldest_q, k_q + CW'(2));
      default:   raddr = oldest_q;
    endcase
  end

  logic [ENTRY_W-1:0] rdata;

  tphi_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr),
    .waddr_i(waddr),
    .wdata_i(wr_entry),
    .re_i   (cmd_i.rd),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_entry = entry_t'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      count_q  <= '0;
    end else if (cmd_i.wr) begin
      if (full) begin
        oldest_q <= slot(oldest_q, CW'(1));
      end else begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  // division step
  logic [TIME_W:0]   rem2;
  logic              step_ge;
  assign rem2    = {rem_q, 1'b0};
  assign step_ge = (rem2 >= {1'b0, den_q});

  // lane arithmetic
  logic signed [DW-1:0] a_lane, b_lane, diff_c;
  logic signed [PW-1:0] prod_c;
  logic signed [SW-1:0] sum_c, sat_c;
  logic                 is_ang;

  assign is_ang = (cmd_i.lane == LANE_HDG) || (cmd_i.lane == LANE_TUR);
  assign a_lane = lane_val(a_q, cmd_i.lane);
  assign b_lane = lane_val(b_q, cmd_i.lane);

  always_comb begin
    diff_c = b_lane - a_lane;
    if (is_ang) begin
      if (diff_c > HALF_C) begin
        diff_c = diff_c - FULL_C;
      end else if (diff_c < -HALF_C) begin
        diff_c = diff_c + FULL_C;
      end
    end
  end

  assign prod_c = diff_q * signed'({1'b0, f_q});
  // floor shift by 16, then add base value
  assign sum_c  = SW'(a_lane) + SW'(signed'(prod_q[PW-1:16]));

  always_comb begin
    sat_c = sum_c;
    if (is_ang) begin
      if (sum_c < ANG_LO) sat_c = ANG_LO;
      else if (sum_c > ANG_HI) sat_c = ANG_HI;
    end else begin
      if (sum_c < POS_LO) sat_c = POS_LO;
      else if (sum_c > POS_HI) sat_c = POS_HI;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else if (cmd_i.k_clr) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + CW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_t) t_q <= sample_time_i;
    if (cmd_i.ld_zero) begin
      a_q <= '0;
      b_q <= '0;
    end
    if (cmd_i.ld_a_rd) a_q <= rd_entry;
    if (cmd_i.ld_b_rd) b_q <= rd_entry;
    if (cmd_i.ld_last) last_q <= rd_entry;
    if (cmd_i.ld_ab_last) begin
      a_q <= last_q;
      b_q <= last_q;
    end
    if (cmd_i.f_clr) f_q <= '0;
    if (cmd_i.f_one) f_q <= 17'h10000;
    if (cmd_i.div_init) begin
      rem_q <= t_q - a_q.ts;
      den_q <= b_q.ts - a_q.ts;
      f_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= step_ge ? rem2[TIME_W-1:0] - den_q : rem2[TIME_W-1:0];
      f_q   <= {f_q[15:0], step_ge};
    end
    if (cmd_i.ld_diff) diff_q <= diff_c;
    if (cmd_i.ld_prod) prod_q <= prod_c;
    if (cmd_i.ld_res) begin
      case (cmd_i.lane)
        LANE_X:   out_x_q   <= sat_c[POS_W-1:0];
        LANE_Y:   out_y_q   <= sat_c[POS_W-1:0];
        LANE_HDG: out_hdg_q <= sat_c[ANG_W-1:0];
        LANE_TUR: out_tur_q <= sat_c[ANG_W-1:0];
        default:  out_x_q   <= sat_c[POS_W-1:0];
      endcase
    end
  end

  assign status_o.cnt_zero = (count_q == '0);
  assign status_o.cnt_one  = (count_q == CW'(1));
  assign status_o.t_le_rd  = (t_q <= rd_entry.ts);
  assign status_o.t_ge_rd  = (t_q >= rd_entry.ts);
  assign status_o.bracket  = (t_q >= a_q.ts) && (t_q <= rd_entry.ts);
  assign status_o.scan_end = ((k_q + CW'(2)) == count_q);
  assign status_o.den_zero = (den_q == '0);
  assign status_o.num_ge   = (rem_q >= den_q);

  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_heading_o = out_hdg_q;
  assign out_turret_o  = out_tur_q;

endmodule
